@@ hw/rtl/induction_motor_model_step_macros.svh @@
// Assertion macros shared by the induction motor model RTL.
`ifndef INDUCTION_MOTOR_MODEL_STEP_MACROS_SVH
`define INDUCTION_MOTOR_MODEL_STEP_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define IMMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("imms assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IMMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("imms assertion failed");

`else

`define IMMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IMMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/imms_pkg.sv @@
// Types, constants and the microcode table of the induction motor model step.
package imms_pkg;

    // Payload of one input transfer.
    typedef struct packed {
        logic signed [31:0] volt_alpha;
        logic signed [31:0] volt_beta;
        logic signed [31:0] load_torque;
    } t_in_item;

    // Payload of one result transfer.
    typedef struct packed {
        logic signed [31:0] phase_a_current;
        logic signed [31:0] phase_b_current;
        logic signed [31:0] phase_c_current;
        logic signed [31:0] alpha_current;
        logic signed [31:0] beta_current;
        logic signed [31:0] elec_torque;
        logic signed [31:0] rotor_speed;
    } t_out_item;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_INV_A           = 3'd0,
        REG_TS_OVER_LSIG    = 3'd1,
        REG_TS_RR_LSIG_LM   = 3'd2,
        REG_INV_B           = 3'd3,
        REG_TS_RR           = 3'd4,
        REG_TS              = 3'd5,
        REG_INV_C           = 3'd6,
        REG_TS_OVER_J       = 3'd7
    } t_reg_idx;

    localparam logic signed [31:0] COEF_ONE    = 32'sd1073741824;
    localparam logic signed [31:0] CONST_NHALF = -32'sd536870912;
    localparam logic signed [31:0] CONST_SQRT3 = 32'sd929887697;

    // Multiplier operand sources.
    typedef enum logic [4:0] {
        SRC_INV_A, SRC_TS_LSIG, SRC_TS_RR_LSIG_LM, SRC_INV_B,
        SRC_TS_RR, SRC_TS, SRC_INV_C, SRC_TS_J,
        SRC_NHALF, SRC_SQRT3,
        SRC_SPEED, SRC_VA, SRC_VB, SRC_TL,
        SRC_CA, SRC_CB, SRC_FA, SRC_FB,
        SRC_WL, SRC_WT, SRC_TX, SRC_TE
    } t_src;

    // Rounding shift applied to each product.
    typedef enum logic [1:0] {
        SH_NONE, SH_16, SH_30
    } t_shift;

    // Starting value of the accumulator; BASE_ACC continues the running sum.
    typedef enum logic [2:0] {
        BASE_ACC, BASE_ZERO, BASE_CA, BASE_CB, BASE_FA, BASE_FB, BASE_SPEED
    } t_base;

    // Register that receives the saturated sum.
    typedef enum logic [3:0] {
        DST_NONE, DST_CA, DST_CB, DST_FA, DST_FB, DST_SPEED,
        DST_WL, DST_WT, DST_TX, DST_TE, DST_PB, DST_PC
    } t_dest;

    // One microcode step: a multiply, then an accumulate and an optional write.
    typedef struct packed {
        t_src   a;
        t_src   b;
        t_shift shift;
        t_base  base;
        logic   sub;     // subtract the term instead of adding it
        logic   post30;  // round the sum by 2^30 before saturating
        t_dest  dest;
        logic   dep;     // an operand is the result of the step before
    } t_uop;

    localparam int unsigned STEP_W = 5;
    localparam logic [STEP_W-1:0] NUM_STEPS = STEP_W'(25);

    function automatic t_uop mk(input t_src a, input t_src b, input t_shift sh,
                                input t_base base, input logic sub,
                                input logic post30, input t_dest dest,
                                input logic dep);
        t_uop u;
        u.a      = a;
        u.b      = b;
        u.shift  = sh;
        u.base   = base;
        u.sub    = sub;
        u.post30 = post30;
        u.dest   = dest;
        u.dep    = dep;
        return u;
    endfunction

    // The update of one sample period. The state registers are overwritten in
    // place as soon as no later step needs their old value.
    function automatic t_uop uop_at(input logic [STEP_W-1:0] step);
        t_uop u;
        case (step)
            // Speed terms from the old speed.
            5'd0:  u = mk(SRC_TS_LSIG, SRC_SPEED, SH_30, BASE_ZERO, 1'b0, 1'b0, DST_WL, 1'b0);
            5'd1:  u = mk(SRC_TS, SRC_SPEED, SH_30, BASE_ZERO, 1'b0, 1'b0, DST_WT, 1'b0);
            // Alpha current.
            5'd2:  u = mk(SRC_TS_LSIG, SRC_VA, SH_30, BASE_CA, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd3:  u = mk(SRC_TS_RR_LSIG_LM, SRC_FB, SH_30, BASE_ACC, 1'b0, 1'b0,
                          DST_NONE, 1'b0);
            5'd4:  u = mk(SRC_WL, SRC_FB, SH_16, BASE_ACC, 1'b0, 1'b0, DST_TX, 1'b0);
            5'd5:  u = mk(SRC_INV_A, SRC_TX, SH_30, BASE_ZERO, 1'b0, 1'b0, DST_CA, 1'b1);
            // Beta current.
            5'd6:  u = mk(SRC_TS_LSIG, SRC_VB, SH_30, BASE_CB, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd7:  u = mk(SRC_TS_RR_LSIG_LM, SRC_FA, SH_30, BASE_ACC, 1'b0, 1'b0,
                          DST_NONE, 1'b0);
            5'd8:  u = mk(SRC_WL, SRC_FA, SH_16, BASE_ACC, 1'b1, 1'b0, DST_TX, 1'b0);
            5'd9:  u = mk(SRC_INV_A, SRC_TX, SH_30, BASE_ZERO, 1'b0, 1'b0, DST_CB, 1'b1);
            // Alpha flux.
            5'd10: u = mk(SRC_TS_RR, SRC_CA, SH_30, BASE_FA, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd11: u = mk(SRC_WT, SRC_FB, SH_16, BASE_ACC, 1'b1, 1'b0, DST_TX, 1'b0);
            5'd12: u = mk(SRC_INV_B, SRC_TX, SH_30, BASE_ZERO, 1'b0, 1'b0, DST_FA, 1'b1);
            // Beta flux, which uses the new alpha flux.
            5'd13: u = mk(SRC_TS_RR, SRC_CB, SH_30, BASE_FB, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd14: u = mk(SRC_WT, SRC_FA, SH_16, BASE_ACC, 1'b1, 1'b0, DST_TX, 1'b0);
            5'd15: u = mk(SRC_INV_B, SRC_TX, SH_30, BASE_ZERO, 1'b0, 1'b0, DST_FB, 1'b1);
            // Electromagnetic torque.
            5'd16: u = mk(SRC_FA, SRC_CB, SH_16, BASE_ZERO, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd17: u = mk(SRC_FB, SRC_CA, SH_16, BASE_ACC, 1'b1, 1'b0, DST_TE, 1'b0);
            // Speed.
            5'd18: u = mk(SRC_TS_J, SRC_TE, SH_30, BASE_SPEED, 1'b0, 1'b0, DST_NONE, 1'b1);
            5'd19: u = mk(SRC_TS_J, SRC_TL, SH_30, BASE_ACC, 1'b1, 1'b0, DST_TX, 1'b0);
            5'd20: u = mk(SRC_INV_C, SRC_TX, SH_30, BASE_ZERO, 1'b0, 1'b0, DST_SPEED, 1'b1);
            // Inverse Clarke, with one rounding of the exact sum.
            5'd21: u = mk(SRC_NHALF, SRC_CA, SH_NONE, BASE_ZERO, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd22: u = mk(SRC_SQRT3, SRC_CB, SH_NONE, BASE_ACC, 1'b0, 1'b1, DST_PB, 1'b0);
            5'd23: u = mk(SRC_NHALF, SRC_CA, SH_NONE, BASE_ZERO, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd24: u = mk(SRC_SQRT3, SRC_CB, SH_NONE, BASE_ACC, 1'b1, 1'b1, DST_PC, 1'b0);
            default: u = mk(SRC_INV_A, SRC_INV_A, SH_NONE, BASE_ACC, 1'b0, 1'b0,
                            DST_NONE, 1'b0);
        endcase
        return u;
    endfunction

endpackage

@@ hw/rtl/induction_motor_model_step.sv @@
// Induction motor model step: one backward-Euler update per input transfer.
//
//  Channel   Direction  Handshake                      Payload
//  -------   ---------  -----------------------------  ----------------------------
//  in        sink       i_in_valid / o_in_stall        i_in_data  (imms_pkg::t_in_item)
//  out       source     o_out_valid / i_out_stall      o_out_data (imms_pkg::t_out_item)
//  config    slave      psel penable pwrite pready     paddr, pwdata, prdata
//
//  From its input transfer until the block can take the next one, when the
//  result register is free, an item passes through an accept cycle, the 25
//  microcode steps through the single 32x32 multiplier, with a wait wherever
//  a step needs the saturated result of the step before it, a drain of the
//  last product, and the load of the result.
//  The shared multiplier and its accumulate stage set the pace of an item.
//  Reset is synchronous and active low; it loads the coefficients with their
//  defaults (unity reciprocals, all other coefficients zero) and clears the
//  motor state. A stalled result holds in the output register while the next
//  item is already computed; only the load of a new result waits for it.
module induction_motor_model_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input item channel.
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  imms_pkg::t_in_item   i_in_data,
    // Result channel.
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output imms_pkg::t_out_item  o_out_data,
    // Configuration port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

`include "induction_motor_model_step_macros.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    localparam logic signed [65:0] RND16 = 66'sd32768;
    localparam logic signed [65:0] RND30 = 66'sd536870912;
    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    // Control and state registers.
    t_state                          r_state,   n_state;
    logic [imms_pkg::STEP_W-1:0]     r_step,    n_step;
    logic [imms_pkg::STEP_W-1:0]     r_mstep,   n_mstep;
    logic                            r_mvalid,  n_mvalid;
    logic                            r_out_valid, n_out_valid;
    imms_pkg::t_out_item             r_out_data,  n_out_data;

    // Coefficients, Q2.30.
    logic signed [31:0] r_inv_a, n_inv_a;
    logic signed [31:0] r_ts_lsig, n_ts_lsig;
    logic signed [31:0] r_ts_rr_lsig_lm, n_ts_rr_lsig_lm;
    logic signed [31:0] r_inv_b, n_inv_b;
    logic signed [31:0] r_ts_rr, n_ts_rr;
    logic signed [31:0] r_ts, n_ts;
    logic signed [31:0] r_inv_c, n_inv_c;
    logic signed [31:0] r_ts_j, n_ts_j;

    // Motor state, Q16.16.
    logic signed [31:0] r_cur_alpha, n_cur_alpha;
    logic signed [31:0] r_cur_beta, n_cur_beta;
    logic signed [31:0] r_flux_alpha, n_flux_alpha;
    logic signed [31:0] r_flux_beta, n_flux_beta;
    logic signed [31:0] r_speed, n_speed;

    // Datapath payload registers.
    imms_pkg::t_in_item r_in, n_in;
    logic signed [63:0] r_prod, n_prod;
    logic signed [65:0] r_acc, n_acc;
    logic signed [31:0] r_wl, n_wl;
    logic signed [31:0] r_wt, n_wt;
    logic signed [31:0] r_tx, n_tx;
    logic signed [31:0] r_te, n_te;
    logic signed [31:0] r_phb, n_phb;
    logic signed [31:0] r_phc, n_phc;

    // Combinational signals.
    imms_pkg::t_uop     iss_u;
    imms_pkg::t_uop     acc_u;
    logic               issue;
    logic               cfg_wr;
    logic               in_xfer;
    logic               out_free;
    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    logic signed [65:0] prod_ext;
    logic signed [65:0] term;
    logic signed [65:0] base_v;
    logic signed [65:0] acc_sum;
    logic signed [65:0] acc_res;
    logic signed [31:0] wval;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] pick(input imms_pkg::t_src s);
        logic signed [31:0] v;
        case (s)
            imms_pkg::SRC_INV_A:         v = r_inv_a;
            imms_pkg::SRC_TS_LSIG:       v = r_ts_lsig;
            imms_pkg::SRC_TS_RR_LSIG_LM: v = r_ts_rr_lsig_lm;
            imms_pkg::SRC_INV_B:         v = r_inv_b;
            imms_pkg::SRC_TS_RR:         v = r_ts_rr;
            imms_pkg::SRC_TS:            v = r_ts;
            imms_pkg::SRC_INV_C:         v = r_inv_c;
            imms_pkg::SRC_TS_J:          v = r_ts_j;
            imms_pkg::SRC_NHALF:         v = imms_pkg::CONST_NHALF;
            imms_pkg::SRC_SQRT3:         v = imms_pkg::CONST_SQRT3;
            imms_pkg::SRC_SPEED:         v = r_speed;
            imms_pkg::SRC_VA:            v = r_in.volt_alpha;
            imms_pkg::SRC_VB:            v = r_in.volt_beta;
            imms_pkg::SRC_TL:            v = r_in.load_torque;
            imms_pkg::SRC_CA:            v = r_cur_alpha;
            imms_pkg::SRC_CB:            v = r_cur_beta;
            imms_pkg::SRC_FA:            v = r_flux_alpha;
            imms_pkg::SRC_FB:            v = r_flux_beta;
            imms_pkg::SRC_WL:            v = r_wl;
            imms_pkg::SRC_WT:            v = r_wt;
            imms_pkg::SRC_TX:            v = r_tx;
            imms_pkg::SRC_TE:            v = r_te;
            default:                     v = '0;
        endcase
        return v;
    endfunction

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign pready      = 1'b1;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !r_out_valid || !i_out_stall;

    // Register readback.
    always_comb begin
        case (imms_pkg::t_reg_idx'(paddr[4:2]))
            imms_pkg::REG_INV_A:         prdata = r_inv_a;
            imms_pkg::REG_TS_OVER_LSIG:  prdata = r_ts_lsig;
            imms_pkg::REG_TS_RR_LSIG_LM: prdata = r_ts_rr_lsig_lm;
            imms_pkg::REG_INV_B:         prdata = r_inv_b;
            imms_pkg::REG_TS_RR:         prdata = r_ts_rr;
            imms_pkg::REG_TS:            prdata = r_ts;
            imms_pkg::REG_INV_C:         prdata = r_inv_c;
            imms_pkg::REG_TS_OVER_J:     prdata = r_ts_j;
            default:                     prdata = '0;
        endcase
    end

    // Issue stage: the step at r_step goes to the multiplier unless it needs
    // the result that the accumulate stage writes in this very cycle.
    assign iss_u = imms_pkg::uop_at(r_step);
    assign issue = (r_state == S_RUN) && (r_step != imms_pkg::NUM_STEPS)
                   && !(r_mvalid && iss_u.dep);

    // The operand muxes read the registers directly, so they must follow
    // every register update, not only a change of the step.
    always_comb begin
        op_a = pick(iss_u.a);
        op_b = pick(iss_u.b);
    end

    // Accumulate stage: round the registered product, add it to the base,
    // and saturate the sum for the destination register.
    assign acc_u    = imms_pkg::uop_at(r_mstep);
    assign prod_ext = {{2{r_prod[63]}}, r_prod};

    always_comb begin
        case (acc_u.shift)
            imms_pkg::SH_16: term = (prod_ext + RND16) >>> 16;
            imms_pkg::SH_30: term = (prod_ext + RND30) >>> 30;
            default:         term = prod_ext;
        endcase
        case (acc_u.base)
            imms_pkg::BASE_ACC:   base_v = r_acc;
            imms_pkg::BASE_CA:    base_v = {{34{r_cur_alpha[31]}}, r_cur_alpha};
            imms_pkg::BASE_CB:    base_v = {{34{r_cur_beta[31]}}, r_cur_beta};
            imms_pkg::BASE_FA:    base_v = {{34{r_flux_alpha[31]}}, r_flux_alpha};
            imms_pkg::BASE_FB:    base_v = {{34{r_flux_beta[31]}}, r_flux_beta};
            imms_pkg::BASE_SPEED: base_v = {{34{r_speed[31]}}, r_speed};
            default:              base_v = '0;
        endcase
        acc_sum = acc_u.sub ? (base_v - term) : (base_v + term);
        acc_res = acc_u.post30 ? ((acc_sum + RND30) >>> 30) : acc_sum;
        wval    = sat32(acc_res);
    end

    // Next-state logic.
    always_comb begin
        n_state         = r_state;
        n_step          = r_step;
        n_mstep         = r_mstep;
        n_mvalid        = issue;
        n_out_valid     = r_out_valid;
        n_out_data      = r_out_data;
        n_inv_a         = r_inv_a;
        n_ts_lsig       = r_ts_lsig;
        n_ts_rr_lsig_lm = r_ts_rr_lsig_lm;
        n_inv_b         = r_inv_b;
        n_ts_rr         = r_ts_rr;
        n_ts            = r_ts;
        n_inv_c         = r_inv_c;
        n_ts_j          = r_ts_j;
        n_cur_alpha     = r_cur_alpha;
        n_cur_beta      = r_cur_beta;
        n_flux_alpha    = r_flux_alpha;
        n_flux_beta     = r_flux_beta;
        n_speed         = r_speed;
        n_in            = r_in;
        n_prod          = r_prod;
        n_acc           = r_acc;
        n_wl            = r_wl;
        n_wt            = r_wt;
        n_tx            = r_tx;
        n_te            = r_te;
        n_phb           = r_phb;
        n_phc           = r_phc;

        if (cfg_wr) begin
            case (imms_pkg::t_reg_idx'(paddr[4:2]))
                imms_pkg::REG_INV_A:         n_inv_a         = pwdata;
                imms_pkg::REG_TS_OVER_LSIG:  n_ts_lsig       = pwdata;
                imms_pkg::REG_TS_RR_LSIG_LM: n_ts_rr_lsig_lm = pwdata;
                imms_pkg::REG_INV_B:         n_inv_b         = pwdata;
                imms_pkg::REG_TS_RR:         n_ts_rr         = pwdata;
                imms_pkg::REG_TS:            n_ts            = pwdata;
                imms_pkg::REG_INV_C:         n_inv_c         = pwdata;
                imms_pkg::REG_TS_OVER_J:     n_ts_j          = pwdata;
                default:                     n_inv_a         = r_inv_a;
            endcase
        end

        // A taken result frees the output register.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (issue) begin
            n_prod  = 64'(op_a) * 64'(op_b);
            n_mstep = r_step;
            n_step  = r_step + imms_pkg::STEP_W'(1);
        end

        if (r_mvalid) begin
            n_acc = acc_sum;
            case (acc_u.dest)
                imms_pkg::DST_CA:    n_cur_alpha  = wval;
                imms_pkg::DST_CB:    n_cur_beta   = wval;
                imms_pkg::DST_FA:    n_flux_alpha = wval;
                imms_pkg::DST_FB:    n_flux_beta  = wval;
                imms_pkg::DST_SPEED: n_speed      = wval;
                imms_pkg::DST_WL:    n_wl         = wval;
                imms_pkg::DST_WT:    n_wt         = wval;
                imms_pkg::DST_TX:    n_tx         = wval;
                imms_pkg::DST_TE:    n_te         = wval;
                imms_pkg::DST_PB:    n_phb        = wval;
                imms_pkg::DST_PC:    n_phc        = wval;
                default:             n_acc        = acc_sum;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_in    = i_in_data;
                    n_step  = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                // With every step issued, the last product is accumulated
                // at this edge.
                if (r_step == imms_pkg::NUM_STEPS) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid                = 1'b1;
                    n_out_data.phase_a_current = r_cur_alpha;
                    n_out_data.phase_b_current = r_phb;
                    n_out_data.phase_c_current = r_phc;
                    n_out_data.alpha_current   = r_cur_alpha;
                    n_out_data.beta_current    = r_cur_beta;
                    n_out_data.elec_torque     = r_te;
                    n_out_data.rotor_speed     = r_speed;
                    n_state                    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer, registered outputs, coefficients and motor state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_step          <= '0;
            r_mstep         <= '0;
            r_mvalid        <= 1'b0;
            r_out_valid     <= 1'b0;
            r_out_data      <= '0;
            r_inv_a         <= imms_pkg::COEF_ONE;
            r_ts_lsig       <= '0;
            r_ts_rr_lsig_lm <= '0;
            r_inv_b         <= imms_pkg::COEF_ONE;
            r_ts_rr         <= '0;
            r_ts            <= '0;
            r_inv_c         <= imms_pkg::COEF_ONE;
            r_ts_j          <= '0;
            r_cur_alpha     <= '0;
            r_cur_beta      <= '0;
            r_flux_alpha    <= '0;
            r_flux_beta     <= '0;
            r_speed         <= '0;
        end else begin
            r_state         <= n_state;
            r_step          <= n_step;
            r_mstep         <= n_mstep;
            r_mvalid        <= n_mvalid;
            r_out_valid     <= n_out_valid;
            r_out_data      <= n_out_data;
            r_inv_a         <= n_inv_a;
            r_ts_lsig       <= n_ts_lsig;
            r_ts_rr_lsig_lm <= n_ts_rr_lsig_lm;
            r_inv_b         <= n_inv_b;
            r_ts_rr         <= n_ts_rr;
            r_ts            <= n_ts;
            r_inv_c         <= n_inv_c;
            r_ts_j          <= n_ts_j;
            r_cur_alpha     <= n_cur_alpha;
            r_cur_beta      <= n_cur_beta;
            r_flux_alpha    <= n_flux_alpha;
            r_flux_beta     <= n_flux_beta;
            r_speed         <= n_speed;
        end
    end

    // Datapath payload registers.
    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_prod <= n_prod;
        r_acc  <= n_acc;
        r_wl   <= n_wl;
        r_wt   <= n_wt;
        r_tx   <= n_tx;
        r_te   <= n_te;
        r_phb  <= n_phb;
        r_phc  <= n_phc;
    end

    // A product is only in flight while the microcode runs.
    `IMMS_ASSERT_IMP(a_mul_only_in_run, i_clk, i_rst_n, r_mvalid, r_state == S_RUN)
    // An input transfer starts the microcode at its first step.
    `IMMS_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_xfer,
        (r_state == S_RUN) && (r_step == '0) && !r_mvalid)
    // The result is only ready once every step has been accumulated.
    `IMMS_ASSERT_IMP(a_done_drained, i_clk, i_rst_n, r_state == S_DONE,
        !r_mvalid && (r_step == imms_pkg::NUM_STEPS))
    // A finished item with a free output register is presented next cycle.
    `IMMS_ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, (r_state == S_DONE) && out_free,
        o_out_valid && (r_state == S_IDLE))

endmodule
